// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: rtl/core/bdds_pkg.sv
package bdds_pkg;

	localparam int VALUE_W = 32;
	localparam int BCD_W   = 4;   // decoder data lines
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 4;

	localparam logic [CNT_W-1:0] CNT_RESET = 4'd3;

	// divide by ten: q = (v * RECIP) >> RECIP_SHIFT, exact for 32-bit v
	localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [IDX_W-1:0] idx;
		logic             last;
	} digit_t;

endpackage

// File: rtl/core/bdds_front.sv
// Accepts numbers and peels off one decimal digit per cycle into the queue while it is not full.
module bdds_front #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bdds_pkg::VALUE_W-1:0]  value,
	input  logic [bdds_pkg::CNT_W-1:0]    digit_count,
	output logic                          push,
	output bdds_pkg::digit_t              push_data,
	input  logic                          q_full
);

	localparam logic [bdds_pkg::CNT_W-1:0] MAX_CNT = bdds_pkg::CNT_W'(MAX_DIGITS);

	logic                         busy_q;
	logic [bdds_pkg::VALUE_W-1:0] val_q;
	logic [bdds_pkg::IDX_W-1:0]   pos_q;
	logic [bdds_pkg::CNT_W-1:0]   cnt_q;

	logic [bdds_pkg::CNT_W-1:0]       eff_cnt;
	logic [2*bdds_pkg::VALUE_W-1:0]   prod;
	logic [bdds_pkg::VALUE_W-1:0]     quot;
	logic [bdds_pkg::VALUE_W-1:0]     quot_x10;
	logic [bdds_pkg::VALUE_W-1:0]     rem;
	logic                             is_last;
	logic                             accept;

	assign eff_cnt = (digit_count > MAX_CNT) ? MAX_CNT : digit_count;

	// v / 10 and v % 10
	assign prod     = {{bdds_pkg::VALUE_W{1'b0}}, val_q} *
	                  {{bdds_pkg::VALUE_W{1'b0}}, bdds_pkg::RECIP};
	assign quot     = bdds_pkg::VALUE_W'(prod >> bdds_pkg::RECIP_SHIFT);
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem      = val_q - quot_x10;

	assign is_last = (pos_q == bdds_pkg::IDX_W'(cnt_q - 1'b1));
	assign push    = busy_q && !q_full;

	assign push_data.bcd  = rem[bdds_pkg::BCD_W-1:0];
	assign push_data.idx  = pos_q;
	assign push_data.last = is_last;

	// a new number may enter on the cycle the last digit goes out
	assign in_ready = !busy_q || (push && is_last);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= (eff_cnt != '0);
		end else if (push && is_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
			pos_q <= '0;
			cnt_q <= eff_cnt;
		end else if (push) begin
			val_q <= quot;
			pos_q <= pos_q + 1'b1;
		end
	end

endmodule

// File: rtl/core/bdds_queue.sv
// Small digit queue between converter and output stage.
module bdds_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bdds_pkg::digit_t din,
	output logic             full,
	input  logic             pop,
	output bdds_pkg::digit_t dout,
	output logic             empty
);

	bdds_pkg::digit_t             mem_q [bdds_pkg::Q_DEPTH];
	logic [bdds_pkg::Q_PTR_W-1:0] wptr_q;
	logic [bdds_pkg::Q_PTR_W-1:0] rptr_q;
	logic [bdds_pkg::Q_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == bdds_pkg::Q_CNT_W'(bdds_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

// File: rtl/core/bdds_back.sv
// Output register: pulls digits from the queue and holds them for the receiver.
module bdds_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  bdds_pkg::digit_t            q_data,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bdds_pkg::BCD_W-1:0]  bcd_code,
	output logic [bdds_pkg::IDX_W-1:0]  select_index,
	output logic                        last_digit
);

	logic             valid_q;
	bdds_pkg::digit_t data_q;

	assign pop = !q_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
		end
	end

	assign out_valid    = valid_q;
	assign bcd_code     = data_q.bcd;
	assign select_index = data_q.idx;
	assign last_digit   = data_q.last;

endmodule

// File: rtl/core/bcd_digit_display_scan.sv
// Multiplexed BCD display scan.
// Input channel (in_valid/in_ready, value): one 32-bit unsigned number per item.
// Output channel (out_valid/out_ready): one item per decimal digit, least
// significant first: bcd_code for the decoder lines, select_index of the
// digit latch to strobe, last_digit on the final digit of the number.
// Config: cfg_we writes cfg_wdata into digit_count (reset 3). Counts above
// MAX_DIGITS act as MAX_DIGITS; a count of zero consumes the number with no
// output. Only write it while the block is idle.
// Overlap: the converter takes a new number in the cycle the last digit of the
// previous one goes to the queue. It makes one digit per cycle, while the queue
// is not full, with a single multiply-by-reciprocal divide-by-ten step.
// Path: converter register, digit queue, output register; later digits follow
// one per cycle while out_ready is high and the queue is not empty.
// Stall: a four-entry digit queue and the output register let the converter
// keep working until the queue fills; the output holds while out_ready is low.
// Reset clears the converter, queue and output valid; digit_count returns to 3.
module bcd_digit_display_scan #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdds_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bdds_pkg::VALUE_W-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bdds_pkg::BCD_W-1:0]    bcd_code,
	output logic [bdds_pkg::IDX_W-1:0]    select_index,
	output logic                          last_digit
);

	logic [bdds_pkg::CNT_W-1:0] digit_count_q;

	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	bdds_pkg::digit_t push_data;
	bdds_pkg::digit_t q_data;

	// digit count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= bdds_pkg::CNT_RESET;
		end else if (cfg_we) begin
			digit_count_q <= cfg_wdata;
		end
	end

	// front: accepts numbers, emits digits one per cycle while the queue is not full
	bdds_front #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.digit_count (digit_count_q),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	// decouples converter from output stalls
	bdds_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_data),
		.empty  (q_empty)
	);

	// back: registered output
	bdds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bcd_code     (bcd_code),
		.select_index (select_index),
		.last_digit   (last_digit)
	);

endmodule

// File: rtl/core/bdds_checker.sv
`include "assert_macros.svh"

// Port-level checks for the display scan.
module bdds_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bdds_pkg::BCD_W-1:0]    bcd_code,
	input logic [bdds_pkg::IDX_W-1:0]    select_index,
	input logic                          last_digit
);

	logic [bdds_pkg::IDX_W-1:0] exp_idx_q;

	// expected position of the next digit in the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= last_digit ? '0 : select_index + 1'b1;
		end
	end

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(bcd_code) && $stable(select_index) && $stable(last_digit))
	`ASSERT_CLK(a_bcd_range, clk, arst_n, out_valid |-> bcd_code < 4'd10)
	`ASSERT_CLK(a_idx_range, clk, arst_n, out_valid |-> select_index < 4'd10)
	`ASSERT_CLK(a_idx_order, clk, arst_n, out_valid |-> select_index == exp_idx_q)
	`ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> !out_valid || $past(arst_n))

endmodule

bind bcd_digit_display_scan bdds_checker u_bdds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.bcd_code     (bcd_code),
	.select_index (select_index),
	.last_digit   (last_digit)
);
